>>> sv/kisstnc_pkg.sv
package kisstnc_pkg;

   // output segment selected by the sequencer
   typedef enum logic [2:0] {
      SEG_PRE      = 3'd0,
      SEG_SRC_SSID = 3'd1,
      SEG_GT       = 3'd2,
      SEG_DEST     = 3'd3,
      SEG_DST_SSID = 3'd4,
      SEG_STAR     = 3'd5,
      SEG_COLON    = 3'd6
   } seg_type;

   // frame status codes carried on the last transfer of a frame
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_PASS  = 2'd1;
   localparam logic [1:0] STAT_TRUNC = 2'd2;
   localparam logic [1:0] STAT_DIGI  = 2'd3;

   localparam logic [7:0] FEND = 8'hC0;

   // controller to datapath
   typedef struct packed {
      logic       accept;
      logic       emit;
      seg_type    seg;
      logic [2:0] idx;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] seg_len;
      logic       out_free;
   } stat_type;

endpackage

>>> sv/kisstnc_chan_if.sv
interface kisstnc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface kisstnc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       char_valid;
   logic       frame_end;
   logic [1:0] status;

   modport source (output valid, output out_char, output char_valid, output frame_end,
                   output status, input ready);
   modport sink (input valid, input out_char, input char_valid, input frame_end,
                 input status, output ready);
endinterface

>>> sv/kisstnc_ctrl.sv
module kisstnc_ctrl
   import kisstnc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_PRE      = 8'b0000_0010,
      ST_SRC_SSID = 8'b0000_0100,
      ST_GT       = 8'b0000_1000,
      ST_DEST     = 8'b0001_0000,
      ST_DST_SSID = 8'b0010_0000,
      ST_STAR     = 8'b0100_0000,
      ST_COLON    = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in, state_nxt;
   logic [2:0] cnt_ff, cnt_in;
   seg_type    seg;

   // segment order after the current one
   always_comb begin
      case (state_ff)
         ST_PRE:      state_nxt = ST_SRC_SSID;
         ST_SRC_SSID: state_nxt = ST_GT;
         ST_GT:       state_nxt = ST_DEST;
         ST_DEST:     state_nxt = ST_DST_SSID;
         ST_DST_SSID: state_nxt = ST_STAR;
         ST_STAR:     state_nxt = ST_COLON;
         default:     state_nxt = ST_IDLE;
      endcase
   end

   // segment select for the datapath
   always_comb begin
      case (state_ff)
         ST_SRC_SSID: seg = SEG_SRC_SSID;
         ST_GT:       seg = SEG_GT;
         ST_DEST:     seg = SEG_DEST;
         ST_DST_SSID: seg = SEG_DST_SSID;
         ST_STAR:     seg = SEG_STAR;
         ST_COLON:    seg = SEG_COLON;
         default:     seg = SEG_PRE;
      endcase
   end

   // sequencer: accept a byte, then walk the segments one result per cycle while output is free
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd.accept = 1'b0;
      cmd.emit   = 1'b0;
      cmd.seg    = seg;
      cmd.idx    = cnt_ff;
      req_ready  = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PRE;
               cnt_in     = 3'd0;
            end
         end
         default: begin
            if (cnt_ff < stat.seg_len) begin
               if (stat.out_free) begin
                  cmd.emit = 1'b1;
                  cnt_in   = cnt_ff + 3'd1;
               end
            end else begin
               cnt_in   = 3'd0;
               state_in = state_nxt;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // an accepted byte always starts at the first segment
   a_accept_to_pre: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_PRE)
      else $error("accept did not start the segment walk");

   // results are only issued inside the segment and into a free output slot
   a_emit_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (cnt_ff < stat.seg_len) && stat.out_free)
      else $error("result issued out of range or into a busy slot");

   // the walk only returns to idle from the last segment
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) ##1 (state_ff == ST_IDLE) |-> $past(state_ff) == ST_COLON)
      else $error("segment walk left early");

endmodule

>>> sv/kisstnc_dp.sv
module kisstnc_dp
   import kisstnc_pkg::*;
#(
   parameter int MAX_DIGIPEATERS = 8
)
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output stat_type   stat,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_frame_end,
   output logic [1:0] rsp_status
);

   localparam int AcBits = $clog2(MAX_DIGIPEATERS + 2);
   localparam int AcW    = (AcBits > 2) ? AcBits : 2;

   localparam logic [7:0] FESC  = 8'hDB;
   localparam logic [7:0] TFEND = 8'hDC;
   localparam logic [7:0] TFESC = 8'hDD;
   localparam logic [6:0] SPACE = 7'h20;

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b000_0001,
      PH_CMD     = 7'b000_0010,
      PH_ADDR    = 7'b000_0100,
      PH_HDR     = 7'b000_1000,
      PH_PAYLOAD = 7'b001_0000,
      PH_PASS    = 7'b010_0000,
      PH_DISCARD = 7'b100_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       frame_end;
      logic [1:0] status;
   } res_type;

   // frame state
   phase_type        phase_ff, phase_in;
   logic             esc_ff, esc_in;
   logic [2:0]       bia_ff, bia_in;
   logic [AcW-1:0]   ac_ff, ac_in;
   logic [1:0]       hsc_ff, hsc_in;
   logic [2:0]       dcc_ff, dcc_in;
   logic [3:0]       dssid_ff, dssid_in;
   logic [1:0]       err_ff, err_in;
   logic [7:0]       dest_chars_ff [6];
   logic             buf_we;

   // results planned for the byte being worked on
   res_type          pre_ff [2];
   res_type          pre_in [2];
   logic [1:0]       pre_cnt_ff, pre_cnt_in;
   logic [3:0]       ssid_ff, ssid_in;
   logic             do_ssid_ff, do_ssid_in;
   logic             do_dest_ff, do_dest_in;
   logic             do_star_ff, do_star_in;
   logic             do_colon_ff, do_colon_in;

   // unescaping
   logic [7:0]       d;
   logic             proceed;
   logic [6:0]       ch;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_ff;
   res_type          res;

   function automatic logic [2:0] ssid_len(input logic [3:0] v);
      logic [2:0] len;
      if (v == 4'd0) len = 3'd0;
      else if (v >= 4'd10) len = 3'd3;
      else len = 3'd2;
      return len;
   endfunction

   function automatic logic [7:0] ssid_char(input logic [3:0] v, input logic [2:0] idx);
      logic [7:0] c;
      if (idx == 3'd0) c = 8'h2D;
      else if (idx == 3'd1) c = (v >= 4'd10) ? 8'h31 : (8'h30 + {4'd0, v});
      else c = 8'h30 + {4'd0, v - 4'd10};
      return c;
   endfunction

   function automatic res_type text(input logic [7:0] c);
      res_type r;
      r.out_char   = c;
      r.char_valid = 1'b1;
      r.frame_end  = 1'b0;
      r.status     = STAT_OK;
      return r;
   endfunction

   function automatic res_type ender(input logic [7:0] c, input logic v, input logic [1:0] s);
      res_type r;
      r.out_char   = c;
      r.char_valid = v;
      r.frame_end  = 1'b1;
      r.status     = s;
      return r;
   endfunction

   assign ch = d[7:1];

   // byte decode: next frame state and the plan of results
   always_comb begin
      phase_in    = phase_ff;
      esc_in      = esc_ff;
      bia_in      = bia_ff;
      ac_in       = ac_ff;
      hsc_in      = hsc_ff;
      dcc_in      = dcc_ff;
      dssid_in    = dssid_ff;
      err_in      = err_ff;
      buf_we      = 1'b0;
      pre_in[0]   = pre_ff[0];
      pre_in[1]   = pre_ff[1];
      pre_cnt_in  = pre_cnt_ff;
      ssid_in     = ssid_ff;
      do_ssid_in  = do_ssid_ff;
      do_dest_in  = do_dest_ff;
      do_star_in  = do_star_ff;
      do_colon_in = do_colon_ff;
      d           = req_rx_byte;
      proceed     = 1'b0;
      if (cmd.accept) begin
         pre_cnt_in  = 2'd0;
         do_ssid_in  = 1'b0;
         do_dest_in  = 1'b0;
         do_star_in  = 1'b0;
         do_colon_in = 1'b0;
         ssid_in     = req_rx_byte[4:1];
         if (req_rx_byte == FEND) begin
            // frame delimiter: close the current frame, open the next
            esc_in   = 1'b0;
            phase_in = PH_CMD;
            case (phase_ff)
               PH_ADDR, PH_HDR: begin
                  pre_in[0]  = ender(8'h00, 1'b0, STAT_TRUNC);
                  pre_cnt_in = 2'd1;
               end
               PH_PAYLOAD: begin
                  pre_in[0]  = ender(8'h00, 1'b0, STAT_OK);
                  pre_cnt_in = 2'd1;
               end
               PH_DISCARD: begin
                  pre_in[0]  = ender(8'h00, 1'b0, err_ff);
                  pre_cnt_in = 2'd1;
               end
               PH_PASS: begin
                  pre_in[0]  = ender(FEND, 1'b1, STAT_PASS);
                  pre_cnt_in = 2'd1;
               end
               default: ;
            endcase
         end else if (phase_ff == PH_CMD) begin
            // command byte
            if (req_rx_byte == 8'h00) begin
               phase_in = PH_ADDR;
               esc_in   = 1'b0;
               bia_in   = 3'd0;
               ac_in    = '0;
               hsc_in   = 2'd0;
               dcc_in   = 3'd0;
               dssid_in = 4'd0;
               err_in   = STAT_OK;
            end else begin
               phase_in   = PH_PASS;
               pre_in[0]  = text(FEND);
               pre_in[1]  = text(req_rx_byte);
               pre_cnt_in = 2'd2;
            end
         end else if (phase_ff == PH_PASS) begin
            pre_in[0]  = text(req_rx_byte);
            pre_cnt_in = 2'd1;
         end else if (phase_ff == PH_ADDR || phase_ff == PH_HDR ||
                      phase_ff == PH_PAYLOAD) begin
            // undo escapes
            if (esc_ff) begin
               esc_in = 1'b0;
               if (req_rx_byte == TFEND) begin
                  d       = FEND;
                  proceed = 1'b1;
               end else if (req_rx_byte == TFESC) begin
                  d       = FESC;
                  proceed = 1'b1;
               end
            end else if (req_rx_byte == FESC) begin
               esc_in = 1'b1;
            end else begin
               proceed = 1'b1;
            end
            if (proceed) begin
               if (phase_ff == PH_ADDR) begin
                  if (bia_ff < 3'd6) begin
                     // callsign character
                     if (ac_ff >= AcW'(2) && bia_ff == 3'd0) begin
                        pre_in[0]  = text(8'h2C);
                        pre_cnt_in = 2'd1;
                     end
                     if (ch != SPACE) begin
                        if (ac_ff == '0) begin
                           if (dcc_ff < 3'd6) begin
                              buf_we = 1'b1;
                              dcc_in = dcc_ff + 3'd1;
                           end
                        end else begin
                           pre_in[pre_cnt_in[0]] = text({1'b0, ch});
                           pre_cnt_in = pre_cnt_in + 2'd1;
                        end
                     end
                     bia_in = bia_ff + 3'd1;
                  end else begin
                     // ssid byte closes the address
                     bia_in = 3'd0;
                     if (ac_ff == '0) begin
                        dssid_in = d[4:1];
                        ac_in    = AcW'(1);
                     end else begin
                        ssid_in    = d[4:1];
                        do_ssid_in = 1'b1;
                        if (ac_ff == AcW'(1)) do_dest_in = 1'b1;
                        else do_star_in = d[7];
                        if (d[0]) begin
                           do_colon_in = 1'b1;
                           hsc_in      = 2'd0;
                           phase_in    = PH_HDR;
                        end else if (ac_ff > AcW'(MAX_DIGIPEATERS)) begin
                           err_in   = STAT_DIGI;
                           phase_in = PH_DISCARD;
                        end else begin
                           ac_in = ac_ff + AcW'(1);
                        end
                     end
                  end
               end else if (phase_ff == PH_HDR) begin
                  // control and pid bytes are skipped
                  if (hsc_ff >= 2'd1) begin
                     hsc_in   = 2'd2;
                     phase_in = PH_PAYLOAD;
                  end else begin
                     hsc_in = hsc_ff + 2'd1;
                  end
               end else begin
                  pre_in[0]  = text(d);
                  pre_cnt_in = 2'd1;
               end
            end
         end
      end
   end

   // segment length, output slot and result selection
   always_comb begin
      res           = text(8'h00);
      stat.out_free = !rsp_valid_ff || rsp_ready;
      case (cmd.seg)
         SEG_PRE: begin
            stat.seg_len = {1'b0, pre_cnt_ff};
            res          = pre_ff[cmd.idx[0]];
         end
         SEG_SRC_SSID: begin
            stat.seg_len = do_ssid_ff ? ssid_len(ssid_ff) : 3'd0;
            res          = text(ssid_char(ssid_ff, cmd.idx));
         end
         SEG_GT: begin
            stat.seg_len = {2'd0, do_dest_ff};
            res          = text(8'h3E);
         end
         SEG_DEST: begin
            stat.seg_len = do_dest_ff ? dcc_ff : 3'd0;
            res          = text(dest_chars_ff[cmd.idx]);
         end
         SEG_DST_SSID: begin
            stat.seg_len = do_dest_ff ? ssid_len(dssid_ff) : 3'd0;
            res          = text(ssid_char(dssid_ff, cmd.idx));
         end
         SEG_STAR: begin
            stat.seg_len = {2'd0, do_star_ff};
            res          = text(8'h2A);
         end
         SEG_COLON: begin
            stat.seg_len = {2'd0, do_colon_ff};
            res          = text(8'h3A);
         end
         default: begin
            stat.seg_len = 3'd0;
         end
      endcase
   end

   // output slot
   assign rsp_valid_in  = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         esc_ff       <= 1'b0;
         bia_ff       <= 3'd0;
         ac_ff        <= '0;
         hsc_ff       <= 2'd0;
         dcc_ff       <= 3'd0;
         dssid_ff     <= 4'd0;
         err_ff       <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         esc_ff       <= esc_in;
         bia_ff       <= bia_in;
         ac_ff        <= ac_in;
         hsc_ff       <= hsc_in;
         dcc_ff       <= dcc_in;
         dssid_ff     <= dssid_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // plan, destination buffer and result payload
   always_ff @(posedge clock) begin
      pre_ff[0]   <= pre_in[0];
      pre_ff[1]   <= pre_in[1];
      pre_cnt_ff  <= pre_cnt_in;
      ssid_ff     <= ssid_in;
      do_ssid_ff  <= do_ssid_in;
      do_dest_ff  <= do_dest_in;
      do_star_ff  <= do_star_in;
      do_colon_ff <= do_colon_in;
      if (buf_we) dest_chars_ff[dcc_ff] <= {1'b0, ch};
      if (cmd.emit) rsp_ff <= res;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = rsp_ff.out_char;
   assign rsp_char_valid = rsp_ff.char_valid;
   assign rsp_frame_end  = rsp_ff.frame_end;
   assign rsp_status     = rsp_ff.status;

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("output slot overwritten");

   // destination buffer fill stays within six characters
   a_dest_fill: assert property (@(posedge clock) disable iff (reset)
      dcc_ff <= 3'd6)
      else $error("destination fill count overran");

   // only the frame end carries a status or a missing character
   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.frame_end |-> rsp_ff.char_valid && rsp_ff.status == STAT_OK)
      else $error("mid-frame result with status or no character");

   // a frame end with a character is always a passthrough delimiter
   a_pass_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_end && rsp_ff.char_valid
         |-> rsp_ff.out_char == FEND && rsp_ff.status == STAT_PASS)
      else $error("frame end character is not a passthrough delimiter");

endmodule

>>> sv/kiss_ax25_to_tnc2_decoder.sv
// one input byte releases 0 to 14 results: the sequencer accepts it, then walks
// seven output segments in order, issuing each segment's results into the output
// register and then moving on; a busy output register holds the walk
// a byte's results are planned into registers at its transfer, then moved into the
// output register; the next byte is taken as soon as the sequencer is idle again
// synchronous active-high reset returns the block to idle outside any frame
module kiss_ax25_to_tnc2_decoder
   import kisstnc_pkg::*;
#(
   parameter int MAX_DIGIPEATERS = 8
)
(
   input  logic            clock,
   input  logic            reset,
   kisstnc_req_if.sink     req_if,
   kisstnc_rsp_if.source   rsp_if
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   kisstnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // frame state, decode and output register
   kisstnc_dp #(
      .MAX_DIGIPEATERS (MAX_DIGIPEATERS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_rx_byte    (req_if.rx_byte),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_out_char   (rsp_if.out_char),
      .rsp_char_valid (rsp_if.char_valid),
      .rsp_frame_end  (rsp_if.frame_end),
      .rsp_status     (rsp_if.status)
   );

endmodule

>>> bench/kisstnc_tb_pkg.sv
package kisstnc_tb_pkg;
   import kisstnc_pkg::*;

   // kiss escape codes
   localparam logic [7:0] FESC  = 8'hDB;
   localparam logic [7:0] TFEND = 8'hDC;
   localparam logic [7:0] TFESC = 8'hDD;

   // tnc2 text characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_GT    = 8'h3E;

   // where the link is within a frame
   typedef enum logic [2:0] {
      LINK_IDLE,
      LINK_CMD,
      LINK_ADDR,
      LINK_HDR,
      LINK_PAYLOAD,
      LINK_PASS,
      LINK_DISCARD
   } link_state_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       frame_end;
      logic [1:0] status;
   } tnc2_result_type;

   class tnc2_scoreboard;
      int unsigned     max_digis;
      link_state_type  state;
      bit              esc_seen;
      int unsigned     call_pos;
      int unsigned     addr_index;
      int unsigned     hdr_count;
      logic [7:0]      dest_call[6];
      int unsigned     dest_len;
      logic [3:0]      dest_ssid;
      logic [1:0]      frame_status;
      tnc2_result_type expected_text[$];
      int unsigned     error_count;

      function new(int unsigned max_digipeaters);
         max_digis = max_digipeaters;
         state = LINK_IDLE;
         esc_seen = 1'b0;
         call_pos = 0;
         addr_index = 0;
         hdr_count = 0;
         dest_len = 0;
         dest_ssid = '0;
         frame_status = STAT_OK;
         error_count = 0;
      endfunction

      function void push_result(logic [7:0] ch, logic vld, logic fend_flag, logic [1:0] st);
         tnc2_result_type r;
         r.out_char = ch;
         r.char_valid = vld;
         r.frame_end = fend_flag;
         r.status = st;
         expected_text.push_back(r);
      endfunction

      function void push_char(logic [7:0] ch);
         push_result(ch, 1'b1, 1'b0, STAT_OK);
      endfunction

      // "-N" suffix, nothing for ssid zero
      function void push_ssid(logic [3:0] ssid);
         logic [3:0] units;
         units = ssid;
         if (ssid == 4'd0) return;
         push_char(CH_DASH);
         if (ssid >= 4'd10) begin
            push_char(CH_ONE);
            units = ssid - 4'd10;
         end
         push_char(CH_ZERO + {4'd0, units});
      endfunction

      // one unescaped byte of the ax.25 address field
      function void address_byte(logic [7:0] d);
         logic [7:0] ch;
         ch = {1'b0, d[7:1]};
         if (call_pos < 6) begin
            if (addr_index >= 2 && call_pos == 0) push_char(CH_COMMA);
            if (ch != CH_SPACE) begin
               if (addr_index == 0) begin
                  if (dest_len < 6) begin
                     dest_call[dest_len] = ch;
                     dest_len++;
                  end
               end else begin
                  push_char(ch);
               end
            end
            call_pos++;
            return;
         end
         call_pos = 0;
         // destination is held back until the source is complete
         if (addr_index == 0) begin
            dest_ssid = d[4:1];
            addr_index = 1;
            return;
         end
         push_ssid(d[4:1]);
         if (addr_index == 1) begin
            push_char(CH_GT);
            for (int i = 0; i < dest_len; i++) push_char(dest_call[i]);
            push_ssid(dest_ssid);
         end else if (d[7]) begin
            push_char(CH_STAR);
         end
         if (d[0]) begin
            push_char(CH_COLON);
            hdr_count = 0;
            state = LINK_HDR;
         end else if (addr_index > max_digis) begin
            frame_status = STAT_DIGI;
            state = LINK_DISCARD;
         end else begin
            addr_index++;
         end
      endfunction

      // works out the text released by one accepted link byte
      function void note_byte(logic [7:0] b);
         logic [7:0] d;
         if (b == FEND) begin
            esc_seen = 1'b0;
            case (state)
               LINK_ADDR, LINK_HDR: push_result(8'h00, 1'b0, 1'b1, STAT_TRUNC);
               LINK_PAYLOAD:        push_result(8'h00, 1'b0, 1'b1, STAT_OK);
               LINK_DISCARD:        push_result(8'h00, 1'b0, 1'b1, frame_status);
               LINK_PASS:           push_result(FEND, 1'b1, 1'b1, STAT_PASS);
               default: ;
            endcase
            state = LINK_CMD;
            return;
         end
         case (state)
            LINK_CMD: begin
               if (b == 8'h00) begin
                  state = LINK_ADDR;
                  esc_seen = 1'b0;
                  call_pos = 0;
                  addr_index = 0;
                  hdr_count = 0;
                  dest_len = 0;
                  dest_ssid = '0;
                  frame_status = STAT_OK;
               end else begin
                  state = LINK_PASS;
                  push_char(FEND);
                  push_char(b);
               end
               return;
            end
            LINK_PASS: begin
               push_char(b);
               return;
            end
            LINK_ADDR, LINK_HDR, LINK_PAYLOAD: ;
            default: return;
         endcase
         // undo kiss escaping
         if (esc_seen) begin
            esc_seen = 1'b0;
            if (b == TFEND) d = FEND;
            else if (b == TFESC) d = FESC;
            else return;
         end else if (b == FESC) begin
            esc_seen = 1'b1;
            return;
         end else begin
            d = b;
         end
         case (state)
            LINK_ADDR: address_byte(d);
            LINK_HDR: begin
               hdr_count++;
               if (hdr_count >= 2) state = LINK_PAYLOAD;
            end
            default: push_char(d);
         endcase
      endfunction

      function int unsigned pending();
         return expected_text.size();
      endfunction

      function void check_result(logic [7:0] out_char, logic char_valid, logic frame_end,
                                 logic [1:0] status);
         tnc2_result_type want;
         if (expected_text.size() == 0) begin
            $error("unexpected transfer: out_char %h char_valid %b frame_end %b status %0d",
                   out_char, char_valid, frame_end, status);
            error_count++;
            return;
         end
         want = expected_text.pop_front();
         if (out_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, out_char);
            error_count++;
         end
         if (char_valid !== want.char_valid) begin
            $error("char_valid: expected %b, got %b", want.char_valid, char_valid);
            error_count++;
         end
         if (frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, frame_end);
            error_count++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            error_count++;
         end
      endfunction
   endclass

endpackage

>>> bench/kiss_ax25_to_tnc2_decoder_tb.sv
module kiss_ax25_to_tnc2_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kisstnc_pkg::*;
   import kisstnc_tb_pkg::*;

   localparam int MAX_DIGIS     = 8;
   localparam int LINK_BYTES    = 410;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;

   logic clock;
   logic reset;

   kisstnc_req_if req_if();
   kisstnc_rsp_if rsp_if();

   tnc2_scoreboard sb;
   logic [7:0]     link_bytes[$];
   int unsigned    send_idle_pct;
   int unsigned    recv_stall_pct;
   int unsigned    cycle_count;

   kiss_ax25_to_tnc2_decoder #(.MAX_DIGIPEATERS(MAX_DIGIS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // escape a frame byte, now and then preceded by a broken escape
   function automatic void push_escaped(ref logic [7:0] q[$], input logic [7:0] b);
      if ($urandom_range(0, 49) == 0) begin
         q.push_back(FESC);
         q.push_back(8'($urandom_range(0, 255)));
      end
      if (b == FEND) begin
         q.push_back(FESC);
         q.push_back(TFEND);
      end else if (b == FESC) begin
         q.push_back(FESC);
         q.push_back(TFESC);
      end else begin
         q.push_back(b);
      end
   endfunction

   // callsign character shifted left, sometimes a space or arbitrary byte
   function automatic logic [7:0] call_byte();
      int unsigned r;
      logic [7:0]  ch;
      r = $urandom_range(0, 49);
      if (r < 12) return 8'($urandom_range(0, 255));
      if (r < 20) begin
         ch = CH_SPACE;
      end else begin
         r = $urandom_range(0, 35);
         ch = (r < 26) ? 8'(8'h41 + r) : 8'(8'h30 + r - 26);
      end
      return {ch[6:0], 1'($urandom_range(0, 1))};
   endfunction

   function automatic logic [7:0] ssid_byte(logic final_addr);
      logic [3:0] ssid;
      ssid = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
      return {1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), ssid, final_addr};
   endfunction

   // data frame, sometimes with too many relays or cut short
   function automatic void add_data_frame();
      logic [7:0]  frame[$];
      int unsigned n_addr;
      int unsigned cut;
      frame.push_back(8'h00);
      if ($urandom_range(0, 4) == 0) n_addr = 2 + $urandom_range(6, 12);
      else n_addr = 2 + $urandom_range(0, 3);
      for (int a = 0; a < n_addr; a++) begin
         for (int k = 0; k < 6; k++) push_escaped(frame, call_byte());
         if (a == 0) push_escaped(frame, ssid_byte(1'($urandom_range(0, 1))));
         else push_escaped(frame, ssid_byte(a == n_addr - 1));
      end
      // control and pid, then payload
      push_escaped(frame, 8'($urandom_range(0, 255)));
      push_escaped(frame, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 8)) push_escaped(frame, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) begin
         cut = $urandom_range(1, frame.size() - 1);
         while (frame.size() > cut) void'(frame.pop_back());
      end
      foreach (frame[i]) link_bytes.push_back(frame[i]);
      link_bytes.push_back(FEND);
   endfunction

   // non-data command frame, echoed raw
   function automatic void add_pass_frame();
      logic [7:0] b;
      b = 8'($urandom_range(1, 255));
      if (b == FEND) b = FESC;
      link_bytes.push_back(b);
      repeat ($urandom_range(0, 6)) begin
         b = 8'($urandom_range(0, 255));
         if (b == FEND) b = 8'hC1;
         link_bytes.push_back(b);
      end
      link_bytes.push_back(FEND);
   endfunction

   function automatic void build_stimulus();
      int unsigned r;
      // stray bytes before the first delimiter, idle fends, a passthrough frame
      // with a raw escape, then a truncated data frame exercising every escape
      link_bytes = '{8'h55, 8'hFF, FEND, FEND, 8'h7F, 8'h00, 8'hFF, FESC, FEND,
                     8'h00, 8'h82, FESC, TFEND, FESC, TFESC, FESC, 8'h12, 8'h40,
                     FESC, FEND};
      while (link_bytes.size() < LINK_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            add_data_frame();
         end else if (r < 85) begin
            add_pass_frame();
         end else if (r < 90) begin
            link_bytes.push_back(FEND);
         end else begin
            repeat ($urandom_range(1, 5)) link_bytes.push_back(8'($urandom_range(0, 255)));
            link_bytes.push_back(FEND);
         end
      end
   endfunction

   // one link byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      sb.note_byte(b);
   endtask

   // result side: random stalls, check every transfer
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         sb.check_result(rsp_if.out_char, rsp_if.char_valid, rsp_if.frame_end, rsp_if.status);
      end
   end

   initial begin
      int unsigned total;
      req_if.valid <= 1'b0;
      req_if.rx_byte <= 8'h00;
      reset <= 1'b1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      sb = new(MAX_DIGIS);
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // four idling phases over the byte stream
      total = link_bytes.size();
      for (int unsigned idx = 0; idx < total; idx++) begin
         case (idx * 4 / total)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 54;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 54;
            end
            default: begin
               send_idle_pct = 27;
               recv_stall_pct = 27;
            end
         endcase
         send_byte(link_bytes[idx]);
      end
      req_if.valid <= 1'b0;

      // drain, then give stray transfers a chance to show
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
